FILE: rtl/ifns_pkg.sv
package ifns_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;

   localparam int PIX_W       = 8;
   localparam int DIM_W       = 9;
   localparam int BIAS_W      = 10;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int SUM_W       = PIX_W + 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [DIM_W-1:0] MIN_WIDTH_D  = DIM_W'(2);
   localparam logic [DIM_W-1:0] MIN_HEIGHT_D = DIM_W'(3);
   localparam logic [DIM_W-1:0] MAX_WIDTH_D  = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_HEIGHT_D = DIM_W'(MAX_HEIGHT);

   localparam logic [DIM_W-1:0]  RESET_FRAME_WIDTH  = DIM_W'(64);
   localparam logic [DIM_W-1:0]  RESET_FRAME_HEIGHT = DIM_W'(64);
   localparam logic [BIAS_W-1:0] RESET_BIAS         = '0;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_BIAS         = CSR_INDEX_W'(2);

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_last;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [CNT_W-1:0] total;
   } cfg_type;

   // One classified result on its way from the front to the back.
   typedef struct packed {
      logic             smooth;
      logic             last;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] below;
      logic [PIX_W-1:0] orig_n;
      logic [PIX_W-1:0] orig_n1;
   } entry_type;

endpackage

FILE: rtl/ifns_front.sv
module ifns_front import ifns_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                restart,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_payload,
   input  logic [QCNT_W-1:0]   queue_count,
   output logic                push,
   output entry_type           push_entry
);

   function automatic logic [COL_W-1:0] col_step(input logic [COL_W-1:0] c,
                                                 input logic [COL_W-1:0] last_col);
      logic [COL_W-1:0] r;
      if (c == last_col) begin
         r = '0;
      end else begin
         r = c + 1'b1;
      end
      return r;
   endfunction

   logic [CNT_W-1:0] inputs_taken_ff, inputs_taken_in;
   logic [CNT_W-1:0] results_given_ff, results_given_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [COL_W-1:0] res_col_ff, res_col_in;

   logic             p1_valid_ff, p1_result_ff;
   logic             p1_smooth_ff, p1_last_ff;
   logic [COL_W-1:0] p1_col_ff;
   logic [PIX_W-1:0] p1_below_ff;
   logic [PIX_W-1:0] orig_rd_ff, orig_prev_ff;
   logic [PIX_W-1:0] orig_line_ff [MAX_WIDTH];

   logic             accept, pixel_take, flush_take, rd_en, result, frame_done, smooth;
   logic [CNT_W-1:0] width_ext;
   logic [CNT_W:0]   rg_plus_one, rg_plus_edge;
   logic [COL_W-1:0] last_col, rd_addr;

   assign req_stall = queue_count > QCNT_W'(QUEUE_DEPTH - 2);
   assign accept    = req_valid && !req_stall;

   assign width_ext = CNT_W'(cfg.width);
   assign last_col  = COL_W'(cfg.width - 1'b1);

   assign pixel_take = accept && (req_payload.opcode == OP_PIXEL)
                       && (inputs_taken_ff < cfg.total);
   assign flush_take = accept && !pixel_take && (inputs_taken_ff >= cfg.total)
                       && (results_given_ff < cfg.total);
   assign rd_en      = pixel_take || flush_take;
   assign result     = (pixel_take && (inputs_taken_ff >= width_ext)) || flush_take;

   // Results leave strictly in raster order, so the pixel being finished is
   // always the one counted by results_given.
   assign rg_plus_one  = {1'b0, results_given_ff} + 1'b1;
   assign rg_plus_edge = {1'b0, results_given_ff} + (CNT_W+1)'(cfg.width)
                         + (CNT_W+1)'(2);
   assign frame_done   = result && (rg_plus_one == {1'b0, cfg.total});
   assign smooth       = (results_given_ff >= width_ext + 1'b1)
                         && (rg_plus_edge <= {1'b0, cfg.total});

   assign rd_addr = pixel_take ? col_step(in_col_ff, last_col)
                               : col_step(res_col_ff, last_col);

   always_comb begin
      inputs_taken_in  = inputs_taken_ff;
      results_given_in = results_given_ff;
      in_col_in        = in_col_ff;
      res_col_in       = res_col_ff;
      if (restart || frame_done) begin
         inputs_taken_in  = '0;
         results_given_in = '0;
         in_col_in        = '0;
         res_col_in       = '0;
      end else begin
         if (pixel_take) begin
            inputs_taken_in = inputs_taken_ff + 1'b1;
            in_col_in       = col_step(in_col_ff, last_col);
         end
         if (result) begin
            results_given_in = results_given_ff + 1'b1;
            res_col_in       = col_step(res_col_ff, last_col);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inputs_taken_ff  <= '0;
         results_given_ff <= '0;
         in_col_ff        <= '0;
         res_col_ff       <= '0;
         p1_valid_ff      <= 1'b0;
         p1_result_ff     <= 1'b0;
      end else begin
         inputs_taken_ff  <= inputs_taken_in;
         results_given_ff <= results_given_in;
         in_col_ff        <= in_col_in;
         res_col_ff       <= res_col_in;
         p1_valid_ff      <= rd_en;
         p1_result_ff     <= result;
      end
   end

   // Each read fetches the original of the pixel after the one being
   // finished; the read before it therefore holds the pixel itself.
   always_ff @(posedge clock) begin
      if (pixel_take) begin
         orig_line_ff[in_col_ff] <= req_payload.pixel_in;
      end
      if (rd_en) begin
         orig_rd_ff   <= orig_line_ff[rd_addr];
         p1_smooth_ff <= smooth;
         p1_last_ff   <= frame_done;
         p1_col_ff    <= res_col_ff;
         p1_below_ff  <= flush_take ? '0 : req_payload.pixel_in;
      end
      if (p1_valid_ff) begin
         orig_prev_ff <= orig_rd_ff;
      end
   end

   assign push       = p1_valid_ff && p1_result_ff;
   assign push_entry = '{smooth:  p1_smooth_ff,
                         last:    p1_last_ff,
                         col:     p1_col_ff,
                         below:   p1_below_ff,
                         orig_n:  orig_prev_ff,
                         orig_n1: orig_rd_ff};

endmodule

FILE: rtl/ifns_queue.sv
module ifns_queue import ifns_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  entry_type         push_entry,
   input  logic              pop,
   output logic              pop_valid,
   output entry_type         pop_entry,
   output logic [QCNT_W-1:0] count
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign pop_valid = count_ff != '0;
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/ifns_back.sv
module ifns_back import ifns_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [BIAS_W-1:0] bias,
   input  logic              pop_valid,
   input  entry_type         pop_entry,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload
);

   logic             x_valid_ff, x_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   entry_type        x_entry_ff;
   logic [PIX_W-1:0] up_ff, left_ff;
   rsp_type          rsp_payload_ff;
   logic [PIX_W-1:0] upd_line_ff [MAX_WIDTH];

   logic             advance;
   logic [SUM_W-1:0] sum;
   logic [PIX_W-1:0] value;

   assign advance = x_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop     = pop_valid && (!x_valid_ff || advance);

   // The left neighbour is simply the previous result, held in left_ff.
   assign sum   = SUM_W'(left_ff) + SUM_W'(up_ff) + SUM_W'(x_entry_ff.orig_n1)
                  + SUM_W'(x_entry_ff.below) + SUM_W'(bias);
   assign value = x_entry_ff.smooth ? sum[PIX_W+1:2] : x_entry_ff.orig_n;

   always_comb begin
      x_valid_in = x_valid_ff;
      if (pop) begin
         x_valid_in = 1'b1;
      end else if (advance) begin
         x_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_valid_ff   <= x_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A column is rewritten when its result leaves this stage, which is always
   // before the pixel one line below fetches it as its upper neighbour.
   always_ff @(posedge clock) begin
      if (pop) begin
         x_entry_ff <= pop_entry;
         up_ff      <= upd_line_ff[pop_entry.col];
      end
      if (advance) begin
         upd_line_ff[x_entry_ff.col] <= value;
         left_ff                     <= value;
         rsp_payload_ff              <= '{pixel_out: value, frame_last: x_entry_ff.last};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: rtl/inplace_four_neighbour_smoother.sv
// In-place four-neighbour smoother for one frame of 8-bit pixels in raster
// order. Pixel n, for width < n < width * height - width - 1, becomes
// (left + right + up + down + bias) >> 2, wrapped to 8 bits, with left and
// up taken from already smoothed pixels; all others pass through. The
// result for pixel n leaves once pixel n + frame_width has been accepted,
// and the last frame_width results are drained by flush transactions (or
// surplus pixels). While req_stall is low the block takes one transaction
// per clock and gives at most one result per clock. A front stage counts
// and classifies transactions and reads the original line buffer, a
// four-entry queue decouples it from the back stage, which reads the
// smoothed line buffer and closes the left-neighbour sum in one add before
// the output register. Results pass the front read register, the queue,
// the back-stage register and the output register. Writing frame_width or
// frame_height restarts the frame; registers are to be written only while
// the block is idle. There is no clearing pass after reset.
module inplace_four_neighbour_smoother import ifns_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [DIM_W-1:0]   frame_width_ff, frame_height_ff;
   logic [BIAS_W-1:0]  bias_ff;

   logic               csr_write, restart;
   logic [DIM_W-1:0]   width_used, height_used;
   logic [2*DIM_W-1:0] product;
   cfg_type            cfg;

   logic               push, pop, pop_valid;
   entry_type          push_entry, pop_entry;
   logic [QCNT_W-1:0]  queue_count;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write
                      && ((csr_index == REG_FRAME_WIDTH) || (csr_index == REG_FRAME_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
         bias_ff         <= RESET_BIAS;
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_data[DIM_W-1:0];
            end
            REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data[DIM_W-1:0];
            end
            REG_BIAS: begin
               bias_ff <= csr_data[BIAS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      width_used = frame_width_ff;
      if (frame_width_ff < MIN_WIDTH_D) begin
         width_used = MIN_WIDTH_D;
      end else if (frame_width_ff > MAX_WIDTH_D) begin
         width_used = MAX_WIDTH_D;
      end
      height_used = frame_height_ff;
      if (frame_height_ff < MIN_HEIGHT_D) begin
         height_used = MIN_HEIGHT_D;
      end else if (frame_height_ff > MAX_HEIGHT_D) begin
         height_used = MAX_HEIGHT_D;
      end
   end

   assign product = (2*DIM_W)'(width_used) * (2*DIM_W)'(height_used);
   assign cfg     = '{width: width_used, total: product[CNT_W-1:0]};

   ifns_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .restart     (restart),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_count (queue_count),
      .push        (push),
      .push_entry  (push_entry)
   );

   ifns_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .count      (queue_count)
   );

   ifns_back u_back (
      .clock       (clock),
      .reset       (reset),
      .bias        (bias_ff),
      .pop_valid   (pop_valid),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
